### rtl/hws_pkg.sv
package hws_pkg;

    // Field and datapath widths
    localparam int READ_W      = 48;
    localparam int LEN_W       = 11;
    localparam int OVL_W       = 10;
    localparam int FACT_W      = 32;
    localparam int SAMPLE_BITS = 24;
    localparam int STD_W       = SAMPLE_BITS - 1;
    localparam int SQR_W       = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W       = SAMPLE_BITS + LEN_W + 1;
    localparam int ARG_W       = 2 * SAMPLE_BITS - 1 + LEN_W;
    localparam int MB_W        = 32;
    localparam int AW          = ARG_W + 1;
    localparam int PROD_W      = AW + MB_W;
    localparam int UCNT_W      = $clog2(ARG_W);
    localparam int FRAC_SHIFT  = 8;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    // Constants
    localparam logic [LEN_W-1:0]       RST_LEN    = LEN_W'(16);
    localparam logic [FACT_W-1:0]      UNIT_FACT  = FACT_W'(65536);
    localparam logic [ARG_W-1:0]       STD_FLOOR  = ARG_W'(7);
    localparam logic [SAMPLE_BITS-1:0] POS_LIM    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] NEG_LIM    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [STD_W-1:0]       STD_LIM    = {STD_W{1'b1}};

    // Register map
    typedef enum logic [2:0] {
        REG_LEN   = 3'd0,
        REG_OVL   = 3'd1,
        REG_SCALE = 3'd2,
        REG_FACT  = 3'd3,
        REG_SENDV = 3'd4,
        REG_SENDS = 3'd5
    } t_reg;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef enum logic {
        KIND_VALUE = 1'b0,
        KIND_STATS = 1'b1
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SMP,
        S_SQR,
        S_ACC,
        S_EMIT_V,
        S_MEAN,
        S_AA,
        S_AAL,
        S_AB,
        S_SUBC,
        S_VDIV,
        S_EL,
        S_BB,
        S_VCHK,
        S_ROOT,
        S_EMIT_S,
        S_HOP,
        S_SCAN_RD,
        S_SCAN_SQ,
        S_SCAN_ACC
    } t_state;

    // Requests to and answers from the shared unit
    typedef struct packed {
        logic             start;
        t_op              op;
        logic [ARG_W-1:0] opa;
        logic [MB_W-1:0]  opb;
    } t_unit_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] product;
        logic [ARG_W-1:0]  quotient;
        logic [ARG_W-1:0]  remainder;
        logic [ARG_W-1:0]  root;
    } t_unit_rsp;

endpackage

### rtl/hws_if.sv
interface hws_in_if;
    logic                        valid;
    logic                        ready;
    logic [hws_pkg::READ_W-1:0]  counter_reading;

    modport source (output valid, output counter_reading, input ready);
    modport sink   (input valid, input counter_reading, output ready);
endinterface

interface hws_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 result_kind;
    logic signed [hws_pkg::SAMPLE_BITS-1:0] sample_value;
    logic signed [hws_pkg::SAMPLE_BITS-1:0] window_min;
    logic signed [hws_pkg::SAMPLE_BITS-1:0] window_max;
    logic signed [hws_pkg::SAMPLE_BITS-1:0] window_mean;
    logic [hws_pkg::STD_W-1:0]            window_std_dev;
    logic                                 last_of_run;

    modport source (output valid, output result_kind, output sample_value,
                    output window_min, output window_max, output window_mean,
                    output window_std_dev, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input sample_value,
                    input window_min, input window_max, input window_mean,
                    input window_std_dev, input last_of_run, output ready);
endinterface

### rtl/hws_unit.sv
module hws_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hws_pkg::t_unit_req i_req,
    output hws_pkg::t_unit_rsp o_rsp
);
    import hws_pkg::*;

    t_op               r_op;
    logic              r_busy;
    logic              r_done;
    logic [UCNT_W-1:0] r_cnt;
    logic [ARG_W-1:0]  r_x;
    logic [ARG_W-1:0]  r_lo;
    logic [AW-1:0]     r_hi;

    logic [AW-1:0]     opx;
    logic [AW-1:0]     opy;
    logic              sub;
    logic [AW:0]       sum;
    logic              ge;
    logic [ARG_W-1:0]  n_x;
    logic [ARG_W-1:0]  n_lo;
    logic [AW-1:0]     n_hi;

    // Shared add/subtract: multiply adds, divide and root compare-subtract
    always_comb begin
        sub = 1'b1;
        opx = '0;
        opy = '0;
        unique case (r_op)
            OP_MUL: begin
                sub = 1'b0;
                opx = r_hi;
                opy = r_lo[0] ? {1'b0, r_x} : '0;
            end
            OP_DIV: begin
                opx = {r_hi[AW-2:0], r_lo[ARG_W-1]};
                opy = {1'b0, r_x};
            end
            OP_SQRT: begin
                opx = {r_hi[AW-3:0], r_lo[ARG_W-1:ARG_W-2]};
                opy = {r_x[AW-3:0], 2'b01};
            end
            default: begin
                opx = '0;
                opy = '0;
            end
        endcase
        sum = {1'b0, opx} + {1'b0, opy ^ {AW{sub}}} + {{AW{1'b0}}, sub};
        ge  = sum[AW];
    end

    // One step of the selected operation
    always_comb begin
        n_x  = r_x;
        n_lo = r_lo;
        n_hi = r_hi;
        unique case (r_op)
            OP_MUL: begin
                n_hi = sum[AW:1];
                n_lo = {sum[0], r_lo[ARG_W-1:1]};
            end
            OP_DIV: begin
                n_hi = ge ? sum[AW-1:0] : opx;
                n_lo = {r_lo[ARG_W-2:0], ge};
            end
            OP_SQRT: begin
                n_hi = ge ? sum[AW-1:0] : opx;
                n_lo = {r_lo[ARG_W-3:0], 2'b00};
                n_x  = {r_x[ARG_W-2:0], ge};
            end
            default: begin
                n_hi = r_hi;
            end
        endcase
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                unique case (i_req.op)
                    OP_MUL:  r_cnt <= UCNT_W'(MB_W - 1);
                    OP_DIV:  r_cnt <= UCNT_W'(ARG_W - 1);
                    OP_SQRT: r_cnt <= UCNT_W'(ARG_W / 2 - 1);
                    default: r_cnt <= '0;
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_hi <= '0;
            unique case (i_req.op)
                OP_MUL: begin
                    r_lo <= ARG_W'(i_req.opb);
                    r_x  <= i_req.opa;
                end
                OP_DIV: begin
                    r_lo <= i_req.opa;
                    r_x  <= ARG_W'(i_req.opb);
                end
                default: begin
                    r_lo <= i_req.opa;
                    r_x  <= '0;
                end
            endcase
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
            r_x  <= n_x;
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.product   = {r_hi, r_lo[ARG_W-1 -: MB_W]};
    assign o_rsp.quotient  = r_lo;
    assign o_rsp.remainder = r_hi[ARG_W-1:0];
    assign o_rsp.root      = r_x;

endmodule

### rtl/hopping_window_statistics.sv
// A sample's value result passes S_SMP (one 32-step multiply in the shared unit),
// then S_SQR, S_ACC and S_EMIT_V, where it is registered at the output.
// A window end with statistics adds up to two 58-step divides, five multiplies and a
// 29-step root, all in the shared unit, then S_SCAN_RD, S_SCAN_SQ and S_SCAN_ACC per carried-over sample.
// A new reading is taken only once the last one is fully processed; ready is high only when idle.
// Reset: synchronous, active low; clears control and sums, sample memory keeps contents.
module hopping_window_statistics #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    hws_in_if.sink                      i_in,
    hws_out_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hws_pkg::ADDR_W-1:0]  paddr,
    input  logic [hws_pkg::DATA_W-1:0]  pwdata,
    output logic [hws_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import hws_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_MAX);

    function automatic logic [LEN_W-1:0] eff_of(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = v;
        if (v == '0) r = LEN_W'(1);
        else if (32'(v) > WINDOW_MAX) r = LEN_W'(WINDOW_MAX);
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (32'(p) == WINDOW_MAX - 1) ? '0 : p + 1'b1;
    endfunction

    // Configuration registers
    logic [LEN_W-1:0]  r_len;
    logic [OVL_W-1:0]  r_ovl;
    logic              r_scale;
    logic [FACT_W-1:0] r_fact;
    logic              r_sendv;
    logic              r_sends;

    // Sequencer and datapath state
    t_state                   r_state, n_state;
    logic                     r_primed;
    logic [READ_W-1:0]        r_prev;
    logic [READ_W-1:0]        r_mag;
    logic                     r_neg;
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic [SQR_W-1:0]         r_sq;
    logic signed [SUM_W-1:0]  r_sum;
    logic [ARG_W-1:0]         r_sqsum;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic [LEN_W-1:0]         r_count;
    logic [PTR_W-1:0]         r_wp;
    logic [PTR_W-1:0]         r_scan_pos;
    logic [LEN_W-1:0]         r_left;
    logic signed [SAMPLE_BITS-1:0] r_rd;
    logic signed [SAMPLE_BITS-1:0] r_mem [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0]   r_a;
    logic [LEN_W-1:0]         r_b;
    logic [ARG_W-1:0]         r_t;
    logic [ARG_W:0]           r_sub;
    logic [ARG_W-1:0]         r_c;
    logic [LEN_W-1:0]         r_e;
    logic [2*LEN_W-1:0]       r_el;
    logic [ARG_W-1:0]         r_var;
    logic [STD_W-1:0]         r_std;
    logic signed [SAMPLE_BITS-1:0] r_mean;

    // Output register
    logic                     r_ov;
    logic                     r_kind;
    logic signed [SAMPLE_BITS-1:0] r_o_smp;
    logic signed [SAMPLE_BITS-1:0] r_o_min;
    logic signed [SAMPLE_BITS-1:0] r_o_max;
    logic signed [SAMPLE_BITS-1:0] r_o_mean;
    logic [STD_W-1:0]         r_o_std;
    logic                     r_last;

    t_unit_req                u_req;
    t_unit_rsp                u_rsp;

    logic [LEN_W-1:0]         len_eff;
    logic                     wen;
    t_reg                     widx;
    logic                     len_clear;
    logic                     in_acc;
    logic                     out_free;
    logic                     wend;
    logic [LEN_W-1:0]         keep;
    logic [LEN_W-1:0]         len_m1;
    logic [PTR_W-1:0]         keep_p;
    logic [PTR_W-1:0]         scan_start;
    logic [SAMPLE_BITS-1:0]   p_lo;
    logic                     p_over;
    logic [SAMPLE_BITS-1:0]   p_val;
    logic signed [SAMPLE_BITS-1:0] x_new;
    logic signed [SAMPLE_BITS-1:0] sq_in;
    logic signed [2*SAMPLE_BITS-1:0] sq_full;
    logic [SUM_W-1:0]         sum_mag;
    logic [SAMPLE_BITS-1:0]   mean_q;

    hws_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .o_rsp   (u_rsp)
    );

    // Config port
    assign pready    = 1'b1;
    assign wen       = psel && penable && pwrite;
    assign widx      = t_reg'(paddr[ADDR_W-1:2]);
    assign len_eff   = eff_of(r_len);
    assign len_clear = wen && (widx == REG_LEN) && (eff_of(pwdata[LEN_W-1:0]) != len_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= RST_LEN;
            r_ovl   <= '0;
            r_scale <= 1'b0;
            r_fact  <= UNIT_FACT;
            r_sendv <= 1'b1;
            r_sends <= 1'b1;
        end else if (wen) begin
            unique case (widx)
                REG_LEN:   r_len   <= pwdata[LEN_W-1:0];
                REG_OVL:   r_ovl   <= pwdata[OVL_W-1:0];
                REG_SCALE: r_scale <= pwdata[0];
                REG_FACT:  r_fact  <= pwdata[FACT_W-1:0];
                REG_SENDV: r_sendv <= pwdata[0];
                REG_SENDS: r_sends <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_LEN:   prdata = DATA_W'(r_len);
            REG_OVL:   prdata = DATA_W'(r_ovl);
            REG_SCALE: prdata = DATA_W'(r_scale);
            REG_FACT:  prdata = DATA_W'(r_fact);
            REG_SENDV: prdata = DATA_W'(r_sendv);
            REG_SENDS: prdata = DATA_W'(r_sends);
            default:   prdata = '0;
        endcase
    end

    // Helpers
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_res.ready;
    assign wend     = (r_count >= len_eff);
    assign len_m1   = len_eff - 1'b1;
    assign keep     = ({1'b0, r_ovl} > len_m1) ? len_m1 : {1'b0, r_ovl};
    assign keep_p   = PTR_W'(keep);
    assign scan_start = (r_wp >= keep_p) ? (r_wp - keep_p)
                      : PTR_W'((PTR_W+1)'(r_wp) + (PTR_W+1)'(WINDOW_MAX) - (PTR_W+1)'(keep_p));

    // Sample from scaled magnitude, saturated
    assign p_lo   = u_rsp.product[FRAC_SHIFT +: SAMPLE_BITS];
    assign p_over = |u_rsp.product[PROD_W-1:FRAC_SHIFT+SAMPLE_BITS];
    always_comb begin
        if (r_neg) begin
            p_val = (p_over || (p_lo > NEG_LIM)) ? NEG_LIM : p_lo;
            x_new = ~p_val + 1'b1;
        end else begin
            p_val = (p_over || p_lo[SAMPLE_BITS-1]) ? POS_LIM : p_lo;
            x_new = p_val;
        end
    end

    assign sq_in   = (r_state == S_SCAN_SQ) ? r_rd : r_smp;
    assign sq_full = sq_in * sq_in;
    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign mean_q  = u_rsp.quotient[SAMPLE_BITS-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (in_acc && r_primed) n_state = S_SMP;
            S_SMP:      if (u_rsp.done) n_state = S_SQR;
            S_SQR:      n_state = S_ACC;
            S_ACC: begin
                if (r_sendv) n_state = S_EMIT_V;
                else if (wend) n_state = r_sends ? S_MEAN : S_HOP;
                else n_state = S_IDLE;
            end
            S_EMIT_V: begin
                if (out_free) begin
                    if (wend) n_state = r_sends ? S_MEAN : S_HOP;
                    else n_state = S_IDLE;
                end
            end
            S_MEAN:     if (u_rsp.done) n_state = S_AA;
            S_AA:       if (u_rsp.done) n_state = S_AAL;
            S_AAL:      if (u_rsp.done) n_state = S_AB;
            S_AB:       if (u_rsp.done) n_state = S_SUBC;
            S_SUBC:     n_state = ({1'b0, r_sqsum} >= r_sub) ? S_VDIV : S_VCHK;
            S_VDIV:     if (u_rsp.done) n_state = S_EL;
            S_EL:       if (u_rsp.done) n_state = S_BB;
            S_BB:       if (u_rsp.done) n_state = S_VCHK;
            S_VCHK:     n_state = (r_var < STD_FLOOR) ? S_EMIT_S : S_ROOT;
            S_ROOT:     if (u_rsp.done) n_state = S_EMIT_S;
            S_EMIT_S:   if (out_free) n_state = S_HOP;
            S_HOP:      n_state = (keep == '0) ? S_IDLE : S_SCAN_RD;
            S_SCAN_RD:  n_state = S_SCAN_SQ;
            S_SCAN_SQ:  n_state = S_SCAN_ACC;
            S_SCAN_ACC: n_state = (r_left == '0) ? S_IDLE : S_SCAN_RD;
            default:    n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: input ready and unit requests
    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        u_req.op   = OP_MUL;
        u_req.opa  = '0;
        u_req.opb  = '0;
        u_req.start = 1'b0;
        unique case (r_state)
            S_SMP: begin
                u_req.start = 1'b1;
                u_req.opa   = ARG_W'(r_mag);
                u_req.opb   = r_scale ? r_fact : UNIT_FACT;
            end
            S_MEAN: begin
                u_req.start = 1'b1;
                u_req.op    = OP_DIV;
                u_req.opa   = ARG_W'(sum_mag);
                u_req.opb   = MB_W'(len_eff);
            end
            S_AA: begin
                u_req.start = 1'b1;
                u_req.opa   = ARG_W'(r_a);
                u_req.opb   = MB_W'(r_a);
            end
            S_AAL: begin
                u_req.start = 1'b1;
                u_req.opa   = r_t;
                u_req.opb   = MB_W'(len_eff);
            end
            S_AB: begin
                u_req.start = 1'b1;
                u_req.opa   = ARG_W'(r_a);
                u_req.opb   = MB_W'(r_b);
            end
            S_VDIV: begin
                u_req.start = 1'b1;
                u_req.op    = OP_DIV;
                u_req.opa   = r_t;
                u_req.opb   = MB_W'(len_eff);
            end
            S_EL: begin
                u_req.start = 1'b1;
                u_req.opa   = ARG_W'(r_e);
                u_req.opb   = MB_W'(len_eff);
            end
            S_BB: begin
                u_req.start = 1'b1;
                u_req.opa   = ARG_W'(r_b);
                u_req.opb   = MB_W'(r_b);
            end
            S_ROOT: begin
                u_req.start = 1'b1;
                u_req.op    = OP_SQRT;
                u_req.opa   = r_var;
            end
            default: u_req.start = 1'b0;
        endcase
        // issue once per op state: unit idle and its previous answer consumed
        u_req.start = u_req.start && !u_rsp.busy && !u_rsp.done;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_primed <= 1'b0;
            r_count  <= '0;
            r_wp     <= '0;
            r_sum    <= '0;
            r_sqsum  <= '0;
            r_left   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (in_acc) r_primed <= 1'b1;
                S_SQR, S_SCAN_SQ: begin
                    r_sum   <= r_sum + SUM_W'(sq_in);
                    r_count <= r_count + 1'b1;
                    if (r_state == S_SQR) r_wp <= ptr_inc(r_wp);
                    else r_left <= r_left - 1'b1;
                end
                S_ACC, S_SCAN_ACC: r_sqsum <= r_sqsum + ARG_W'(r_sq);
                S_HOP: begin
                    r_count <= '0;
                    r_sum   <= '0;
                    r_sqsum <= '0;
                    r_left  <= keep;
                end
                default: ;
            endcase
            // a length change empties the window
            if (len_clear) begin
                r_count <= '0;
                r_sum   <= '0;
                r_sqsum <= '0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_prev <= i_in.counter_reading;
                    r_neg  <= (i_in.counter_reading < r_prev);
                    r_mag  <= (i_in.counter_reading < r_prev)
                            ? r_prev - i_in.counter_reading
                            : i_in.counter_reading - r_prev;
                end
            end
            S_SMP: if (u_rsp.done) r_smp <= x_new;
            S_SQR, S_SCAN_SQ: begin
                r_sq <= sq_full[SQR_W-1:0];
                if (r_count == '0) begin
                    r_min <= sq_in;
                    r_max <= sq_in;
                end else begin
                    if (sq_in < r_min) r_min <= sq_in;
                    if (sq_in > r_max) r_max <= sq_in;
                end
                if (r_state == S_SCAN_SQ) r_scan_pos <= ptr_inc(r_scan_pos);
            end
            S_MEAN: begin
                if (u_rsp.done) begin
                    r_a    <= mean_q;
                    r_b    <= u_rsp.remainder[LEN_W-1:0];
                    r_mean <= r_sum[SUM_W-1] ? (~mean_q + 1'b1) : mean_q;
                end
            end
            S_AA, S_AAL: if (u_rsp.done) r_t <= u_rsp.product[ARG_W-1:0];
            S_AB: if (u_rsp.done) r_sub <= {1'b0, r_t} + {u_rsp.product[ARG_W-1:0], 1'b0};
            S_SUBC: begin
                if ({1'b0, r_sqsum} >= r_sub) r_t <= r_sqsum - r_sub[ARG_W-1:0];
                else r_var <= '0;
            end
            S_VDIV: begin
                if (u_rsp.done) begin
                    r_c <= u_rsp.quotient;
                    r_e <= u_rsp.remainder[LEN_W-1:0];
                end
            end
            S_EL: if (u_rsp.done) r_el <= u_rsp.product[2*LEN_W-1:0];
            S_BB: begin
                if (u_rsp.done) begin
                    // remainder correction of the variance quotient
                    r_var <= ((r_el < u_rsp.product[2*LEN_W-1:0]) && (r_c != '0))
                           ? r_c - 1'b1 : r_c;
                end
            end
            S_VCHK: if (r_var < STD_FLOOR) r_std <= '0;
            S_ROOT: begin
                if (u_rsp.done) begin
                    r_std <= (u_rsp.root > ARG_W'(STD_LIM)) ? STD_LIM
                           : u_rsp.root[STD_W-1:0];
                end
            end
            S_HOP: r_scan_pos <= scan_start;
            default: ;
        endcase
    end

    // Sample memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_SQR) r_mem[r_wp] <= r_smp;
        r_rd <= r_mem[r_scan_pos];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (((r_state == S_EMIT_V) || (r_state == S_EMIT_S)) && out_free) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT_V) && out_free) begin
            r_kind   <= KIND_VALUE;
            r_o_smp  <= r_smp;
            r_o_min  <= '0;
            r_o_max  <= '0;
            r_o_mean <= '0;
            r_o_std  <= '0;
            r_last   <= !(wend && r_sends);
        end else if ((r_state == S_EMIT_S) && out_free) begin
            r_kind   <= KIND_STATS;
            r_o_smp  <= '0;
            r_o_min  <= r_min;
            r_o_max  <= r_max;
            r_o_mean <= r_mean;
            r_o_std  <= r_std;
            r_last   <= 1'b1;
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.result_kind    = r_kind;
    assign o_res.sample_value   = r_o_smp;
    assign o_res.window_min     = r_o_min;
    assign o_res.window_max     = r_o_max;
    assign o_res.window_mean    = r_o_mean;
    assign o_res.window_std_dev = r_o_std;
    assign o_res.last_of_run    = r_last;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count < len_eff))
        else $error("window count reached length while idle");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && (r_count != '0)) |-> (r_min <= r_max))
        else $error("window min above max");

    a_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !u_rsp.busy)
        else $error("shared unit busy while sequencer idle");

    a_stats_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_kind == KIND_STATS)) |-> r_last)
        else $error("statistics item not marked last");

endmodule
